[rtl/mvsm_pkg.sv]
// Package for the multi-voice sample mixer: widths, op codes and the controller
// command struct. No dependencies.
`default_nettype none
package mvsm_pkg;
  localparam int unsigned VoicesDef      = 16;
  localparam int unsigned SampleDepthDef = 65536;
  localparam int unsigned PosW  = 33;
  localparam int unsigned LenW  = 17;
  localparam int unsigned GainW = 16;
  localparam int unsigned StepW = 24;
  localparam int unsigned SumW  = 40;
  localparam logic signed [SumW-1:0] MixMax = 40'sd32767;
  localparam logic signed [SumW-1:0] MixMin = -40'sd32767;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpStart = 2'd1,
    OpTick  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // clear the channel sums
    logic acc;      // accumulate the voice whose data returned
    logic adv;      // advance position of the accumulated voice
    logic finish;   // latch clamped sums into output register
  } mvsm_cmd_t;
endpackage
`default_nettype wire

[rtl/mvsm_if.sv]
// Valid/ready channel interfaces for the mixer.
// Depends on nothing.
`default_nettype none
interface mvsm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [15:0]       sample_addr;
  logic signed [15:0] sample_left;
  logic signed [15:0] sample_right;
  logic [15:0]       voice_start;
  logic [16:0]       voice_length;
  logic [15:0]       gain_left;
  logic [15:0]       gain_right;
  logic [23:0]       step;
  modport source(output valid, op, sample_addr, sample_left, sample_right, voice_start,
                 voice_length, gain_left, gain_right, step, input ready);
  modport sink(input valid, op, sample_addr, sample_left, sample_right, voice_start,
               voice_length, gain_left, gain_right, step, output ready);
endinterface

interface mvsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  modport source(output valid, left_out, right_out, input ready);
  modport sink(input valid, left_out, right_out, output ready);
endinterface

interface mvsm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/multi_voice_sample_mixer_unit.sv]
// Multi-voice sample mixer top level. A tick walks the voices through the
// sample memory read port, one voice per cycle, and then latches its output
// frame. Items are accepted while a frame waits; a tick that ends before the
// previous frame is transferred holds in its done state. Reset frees all
// voices and sets enable; sample memory is not cleared.
`default_nettype none
module multi_voice_sample_mixer_unit #(
  parameter int unsigned Voices      = mvsm_pkg::VoicesDef,
  parameter int unsigned SampleDepth = mvsm_pkg::SampleDepthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mvsm_in_if.sink    in_ch,
  mvsm_out_if.source out_ch,
  mvsm_cfg_if.sink   cfg_ch
);
  localparam int unsigned VW = (Voices > 1) ? $clog2(Voices) : 1;

  mvsm_pkg::mvsm_cmd_t cmd;
  logic [VW-1:0] rd_voice, acc_voice;
  logic wr, start, enable_q;
  logic [15:0] left, right;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_ch.valid) begin
      enable_q <= cfg_ch.data;
    end
  end

  mvsm_ctrl #(.Voices(Voices)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .op_i       (in_ch.op),
    .enable_i   (enable_q),
    .len_zero_i (in_ch.voice_length == 17'd0),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .cmd_o      (cmd),
    .rd_voice_o (rd_voice),
    .acc_voice_o(acc_voice),
    .wr_o       (wr),
    .start_o    (start)
  );

  mvsm_datapath #(.Voices(Voices), .SampleDepth(SampleDepth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_voice_i    (rd_voice),
    .acc_voice_i   (acc_voice),
    .wr_i          (wr),
    .start_i       (start),
    .sample_addr_i (in_ch.sample_addr),
    .sample_left_i (in_ch.sample_left),
    .sample_right_i(in_ch.sample_right),
    .voice_start_i (in_ch.voice_start),
    .voice_length_i(in_ch.voice_length),
    .gain_left_i   (in_ch.gain_left),
    .gain_right_i  (in_ch.gain_right),
    .step_i        (in_ch.step),
    .left_o        (left),
    .right_o       (right)
  );

  assign out_ch.left_out  = left;
  assign out_ch.right_out = right;
endmodule
`default_nettype wire

[rtl/mvsm_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mvsm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/mvsm_datapath.sv]
// Mixer datapath: voice registers, sample memory, multipliers, sums, output.
// Depends on mvsm_pkg and mvsm_ram.
`default_nettype none
module mvsm_datapath #(
  parameter int unsigned Voices      = mvsm_pkg::VoicesDef,
  parameter int unsigned SampleDepth = mvsm_pkg::SampleDepthDef,
  localparam int unsigned VW = (Voices > 1) ? $clog2(Voices) : 1,
  localparam int unsigned AW = $clog2(SampleDepth)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mvsm_pkg::mvsm_cmd_t cmd_i,
  input  wire logic [VW-1:0]     rd_voice_i,
  input  wire logic [VW-1:0]     acc_voice_i,
  input  wire logic              wr_i,
  input  wire logic              start_i,
  input  wire logic [15:0]       sample_addr_i,
  input  wire logic [15:0]       sample_left_i,
  input  wire logic [15:0]       sample_right_i,
  input  wire logic [15:0]       voice_start_i,
  input  wire logic [16:0]       voice_length_i,
  input  wire logic [15:0]       gain_left_i,
  input  wire logic [15:0]       gain_right_i,
  input  wire logic [23:0]       step_i,
  output logic [15:0]            left_o,
  output logic [15:0]            right_o
);
  logic [Voices-1:0]            act_q;
  logic [15:0]                  base_q [Voices];
  logic [mvsm_pkg::LenW-1:0]    len_q  [Voices];
  logic [mvsm_pkg::PosW-1:0]    pos_q  [Voices];
  logic [mvsm_pkg::GainW-1:0]   gl_q   [Voices];
  logic [mvsm_pkg::GainW-1:0]   gr_q   [Voices];
  logic [mvsm_pkg::StepW-1:0]   stp_q  [Voices];
  logic signed [mvsm_pkg::SumW-1:0] sum_l_q, sum_r_q;
  logic [31:0]                  rdata;
  logic [AW-1:0]                raddr, waddr;
  logic [VW-1:0]                free_idx;
  logic                         found;
  logic [mvsm_pkg::PosW-1:0]    pos_nx;
  logic signed [32:0]           pl, pr;
  logic signed [mvsm_pkg::SumW-1:0] tl, tr;

  // Lowest free voice. A start with no free voice is dropped.
  always_comb begin
    free_idx = '0;
    found    = 1'b0;
    for (int i = Voices - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_idx = VW'(i);
        found    = 1'b1;
      end
    end
  end

  assign waddr = AW'(sample_addr_i);
  assign raddr = AW'({16'd0, base_q[rd_voice_i]} + 32'(pos_q[rd_voice_i][32:16]));

  mvsm_ram #(.Width(32), .Depth(SampleDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i),
    .waddr_i(waddr),
    .wdata_i({sample_right_i, sample_left_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Product, then truncate toward zero: add 4095 to negatives before shifting.
  always_comb begin
    pl = $signed(rdata[15:0]) * $signed({1'b0, gl_q[acc_voice_i]});
    pr = $signed(rdata[31:16]) * $signed({1'b0, gr_q[acc_voice_i]});
    tl = mvsm_pkg::SumW'((pl + (pl[32] ? 33'sd4095 : 33'sd0)) >>> 12);
    tr = mvsm_pkg::SumW'((pr + (pr[32] ? 33'sd4095 : 33'sd0)) >>> 12);
    pos_nx = pos_q[acc_voice_i] + mvsm_pkg::PosW'(stp_q[acc_voice_i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (start_i && found) begin
      act_q[free_idx] <= 1'b1;
    end else if (cmd_i.adv && act_q[acc_voice_i]) begin
      if (pos_nx[32:16] >= len_q[acc_voice_i]) begin
        act_q[acc_voice_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && found) begin
      base_q[free_idx] <= voice_start_i;
      len_q[free_idx]  <= voice_length_i;
      pos_q[free_idx]  <= '0;
      gl_q[free_idx]   <= gain_left_i;
      gr_q[free_idx]   <= gain_right_i;
      stp_q[free_idx]  <= step_i;
    end else if (cmd_i.adv && act_q[acc_voice_i]) begin
      pos_q[acc_voice_i] <= pos_nx;
    end
    if (cmd_i.clear) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (cmd_i.acc && act_q[acc_voice_i]) begin
      sum_l_q <= sum_l_q + tl;
      sum_r_q <= sum_r_q + tr;
    end
    if (cmd_i.finish) begin
      left_o  <= (sum_l_q > mvsm_pkg::MixMax) ? 16'sd32767 :
                 (sum_l_q < mvsm_pkg::MixMin) ? -16'sd32767 : sum_l_q[15:0];
      right_o <= (sum_r_q > mvsm_pkg::MixMax) ? 16'sd32767 :
                 (sum_r_q < mvsm_pkg::MixMin) ? -16'sd32767 : sum_r_q[15:0];
    end
  end
endmodule
`default_nettype wire

[rtl/mvsm_ctrl.sv]
// Mixer controller: accepts items, sequences the voice walk of a tick,
// and holds the output valid. Depends on mvsm_pkg.
`default_nettype none
module mvsm_ctrl #(
  parameter int unsigned Voices = mvsm_pkg::VoicesDef,
  localparam int unsigned VW = (Voices > 1) ? $clog2(Voices) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    op_i,
  input  wire logic          enable_i,
  input  wire logic          len_zero_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mvsm_pkg::mvsm_cmd_t cmd_o,
  output logic [VW-1:0]      rd_voice_o,
  output logic [VW-1:0]      acc_voice_o,
  output logic               wr_o,
  output logic               start_o
);
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [VW:0]    cnt_q, cnt_d;     // issued reads
  logic           pend_q, pend_d;   // read data returns this cycle
  logic [VW-1:0]  accv_q, accv_d;
  logic           ov_q, ov_d;
  logic           acc_in;

  assign acc_in      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign wr_o        = acc_in && (op_i == mvsm_pkg::OpWrite);
  assign start_o     = acc_in && (op_i == mvsm_pkg::OpStart) && enable_i && !len_zero_i;
  assign rd_voice_o  = cnt_q[VW-1:0];
  assign acc_voice_o = accv_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    accv_d  = accv_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (acc_in && op_i == mvsm_pkg::OpTick) begin
          cmd_o.clear = 1'b1;
          cnt_d       = '0;
          state_d     = StRun;
        end
      end
      StRun: begin
        if (pend_q) begin
          cmd_o.acc = 1'b1;
          cmd_o.adv = 1'b1;
        end
        if (cnt_q < (VW+1)'(Voices)) begin
          pend_d = 1'b1;
          accv_d = cnt_q[VW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end else if (!pend_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Wait here while the previous frame is still in the output register.
        if (!ov_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ov_d         = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      accv_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      accv_q  <= accv_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire
